// File: design/systematic_resampler_top_defines.svh
// Assertion macros used by the port checker.
`ifndef SYSTEMATIC_RESAMPLER_TOP_DEFINES_SVH
`define SYSTEMATIC_RESAMPLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/sr_pkg.sv
package sr_pkg;

   localparam int MAX_PARTICLES = 1024;
   localparam int IDX_W         = $clog2(MAX_PARTICLES);
   localparam int CNT_W         = 11;
   localparam int SUM_W         = 27;
   localparam int WEIGHT_W      = 17;
   localparam int OFFS_W        = 16;
   localparam int STEP_W        = 17;
   localparam int CSR_DATA_W    = 17;

   localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(1024);
   localparam logic [STEP_W-1:0] STEP_RESET  = STEP_W'(64);

   typedef enum logic [0:0] {
      CSR_PARTICLE_COUNT = 1'b0,
      CSR_THRESHOLD_STEP = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      OP_LOAD = 1'b0,
      OP_DRAW = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      S_IDLE = 1'b0,
      S_SCAN = 1'b1
   } state_type;

   typedef struct packed {
      logic                operation;
      logic [WEIGHT_W-1:0] weight;
      logic [OFFS_W-1:0]   start_offset;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] particle_index;
      logic             last_of_pass;
      logic             ran_past_end;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic draw;
      logic advance;
      logic finish;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic advance_ok;
   } status_type;

   // Add with saturation at the top of the sum range.
   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [STEP_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + (SUM_W+1)'(b);
      return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
   endfunction

endpackage

// File: design/systematic_resampler_top.sv
// Systematic resampler for a particle filter.
// Input channel: a transaction is taken on a rising edge with start high and busy low;
// req_data carries operation, weight and start_offset.
// Load transactions (operation 0) store the running cumulative weight of the next
// particle; they keep busy low, so loads may come every cycle unless a draw holds busy.
// Draw transactions (operation 1) form a pass of particle_count draws; the first draw
// of a pass uses start_offset as threshold, each later one adds threshold_step.
// While a draw searches, busy is high and the selection pointer walks the
// cumulative weight memory one entry a cycle through its single registered read
// port. Over a pass the pointer moves at most once per particle.
// Result channel: rsp_valid strobes for one cycle with rsp_data (particle_index,
// last_of_pass, ran_past_end); the receiver has no way to stall it.
// Configuration: csr_we writes csr_wdata into register csr_index (0 particle_count,
// 1 threshold_step) at once; write only while idle.
// Reset (synchronous, active high) clears positions and sums and restores
// particle_count 1024 and threshold_step 64; the weight memory is not cleared.
module systematic_resampler_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  sr_pkg::req_type                req_data,
   output logic                           rsp_valid,
   output sr_pkg::rsp_type                rsp_data,
   input  logic                           csr_we,
   input  logic [0:0]                     csr_index,
   input  logic [sr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   sr_pkg::cmd_type    cmd;
   sr_pkg::status_type status;

   sr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_data.operation),
      .status        (status),
      .busy          (busy),
      .cmd           (cmd)
   );

   sr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: design/sr_ctrl.sv
module sr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_operation,
   input  sr_pkg::status_type   status,
   output logic                 busy,
   output sr_pkg::cmd_type      cmd
);

   sr_pkg::state_type state_ff, state_in;

   // Hold the sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sr_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decode next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b0;
      unique case (state_ff)
         sr_pkg::S_IDLE: begin
            if (start) begin
               if (req_operation == sr_pkg::OP_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.draw = 1'b1;
                  state_in = sr_pkg::S_SCAN;
               end
            end
         end
         sr_pkg::S_SCAN: begin
            busy = 1'b1;
            if (status.advance_ok) begin
               cmd.advance = 1'b1;
            end else begin
               cmd.finish = 1'b1;
               state_in   = sr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sr_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// File: design/sr_datapath.sv
module sr_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  sr_pkg::req_type                   req_data,
   input  sr_pkg::cmd_type                   cmd,
   input  logic                              csr_we,
   input  logic [0:0]                        csr_index,
   input  logic [sr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output sr_pkg::status_type                status,
   output logic                              rsp_valid,
   output sr_pkg::rsp_type                   rsp_data
);

   logic [sr_pkg::CNT_W-1:0]  count_ff;
   logic [sr_pkg::STEP_W-1:0] step_ff;
   logic [sr_pkg::SUM_W-1:0]  run_sum_ff, run_sum_in;
   logic [sr_pkg::IDX_W-1:0]  load_pos_ff, load_pos_in;
   logic [sr_pkg::IDX_W-1:0]  draw_pos_ff, draw_pos_in;
   logic [sr_pkg::IDX_W-1:0]  sel_ff, sel_in;
   logic [sr_pkg::SUM_W-1:0]  thr_ff, thr_in;
   logic [sr_pkg::SUM_W-1:0]  rd_data_ff;
   logic                      rsp_valid_ff;
   sr_pkg::rsp_type           rsp_ff, rsp_in;

   logic [sr_pkg::SUM_W-1:0]  cum_mem [sr_pkg::MAX_PARTICLES];

   logic [sr_pkg::CNT_W-1:0]  n_eff;
   logic [sr_pkg::CNT_W-1:0]  n_m1;
   logic [sr_pkg::IDX_W-1:0]  last_idx;
   logic [sr_pkg::IDX_W-1:0]  load_pos;
   logic [sr_pkg::IDX_W-1:0]  draw_pos;
   logic [sr_pkg::SUM_W-1:0]  load_base;
   logic [sr_pkg::SUM_W-1:0]  load_sum;
   logic                      above;
   sr_pkg::csr_index_type     csr_sel;

   // Clamp the particle count to the supported range.
   always_comb begin
      if (count_ff == '0) begin
         n_eff = sr_pkg::CNT_W'(1);
      end else if (count_ff > sr_pkg::CNT_W'(sr_pkg::MAX_PARTICLES)) begin
         n_eff = sr_pkg::CNT_W'(sr_pkg::MAX_PARTICLES);
      end else begin
         n_eff = count_ff;
      end
      n_m1     = n_eff - sr_pkg::CNT_W'(1);
      last_idx = n_m1[sr_pkg::IDX_W-1:0];
   end

   // Drop stale positions left over from a larger count.
   assign load_pos = ({1'b0, load_pos_ff} >= n_eff) ? '0 : load_pos_ff;
   assign draw_pos = ({1'b0, draw_pos_ff} >= n_eff) ? '0 : draw_pos_ff;

   // Accumulate the running weight sum; restart at the first particle.
   assign load_base = (load_pos == '0) ? '0 : run_sum_ff;
   assign load_sum  = sr_pkg::sat_add(load_base, req_data.weight);

   assign above             = thr_ff > rd_data_ff;
   assign status.advance_ok = (sel_ff < last_idx) && above;

   // Next values of the sequencing registers.
   always_comb begin
      run_sum_in  = run_sum_ff;
      load_pos_in = load_pos_ff;
      draw_pos_in = draw_pos_ff;
      sel_in      = sel_ff;
      thr_in      = thr_ff;
      rsp_in      = rsp_ff;
      if (cmd.load) begin
         run_sum_in  = load_sum;
         load_pos_in = (load_pos == last_idx) ? '0 : load_pos + sr_pkg::IDX_W'(1);
      end
      if (cmd.draw) begin
         draw_pos_in = draw_pos;
         if (draw_pos == '0) begin
            thr_in = sr_pkg::SUM_W'(req_data.start_offset);
            sel_in = '0;
         end else begin
            thr_in = sr_pkg::sat_add(thr_ff, step_ff);
            sel_in = (sel_ff > last_idx) ? last_idx : sel_ff;
         end
      end
      if (cmd.advance) begin
         sel_in = sel_ff + sr_pkg::IDX_W'(1);
      end
      if (cmd.finish) begin
         rsp_in.particle_index = sel_ff;
         rsp_in.last_of_pass   = (draw_pos_ff == last_idx);
         rsp_in.ran_past_end   = above;
         draw_pos_in = (draw_pos_ff == last_idx) ? '0 : draw_pos_ff + sr_pkg::IDX_W'(1);
      end
   end

   // Write configuration registers.
   assign csr_sel = sr_pkg::csr_index_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= sr_pkg::COUNT_RESET;
         step_ff  <= sr_pkg::STEP_RESET;
      end else if (csr_we) begin
         unique case (csr_sel)
            sr_pkg::CSR_PARTICLE_COUNT: count_ff <= csr_wdata[sr_pkg::CNT_W-1:0];
            sr_pkg::CSR_THRESHOLD_STEP: step_ff  <= csr_wdata[sr_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance the control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_sum_ff   <= '0;
         load_pos_ff  <= '0;
         draw_pos_ff  <= '0;
         sel_ff       <= '0;
         thr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_sum_ff   <= run_sum_in;
         load_pos_ff  <= load_pos_in;
         draw_pos_ff  <= draw_pos_in;
         sel_ff       <= sel_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= cmd.finish;
      end
   end

   // Hold the result payload.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Cumulative weight memory: one write, one registered read at the next pointer.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cum_mem[load_pos] <= load_sum;
      end
      rd_data_ff <= cum_mem[sel_in];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: design/sr_port_checker.sv
`include "systematic_resampler_top_defines.svh"

module sr_port_checker (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic            busy,
   input  sr_pkg::req_type req_data,
   input  logic            rsp_valid
);

   logic load_acc;
   logic draw_acc;

   assign load_acc = start && !busy && (req_data.operation == sr_pkg::OP_LOAD);
   assign draw_acc = start && !busy && (req_data.operation == sr_pkg::OP_DRAW);

   // A draw transaction always enters a busy search.
   `SR_ASSERT_NEXT(a_draw_busy, clock, reset, draw_acc, busy, "draw did not raise busy")
   // A load transaction completes in its accept cycle.
   `SR_ASSERT_NEXT(a_load_free, clock, reset, load_acc, !busy && !rsp_valid, "load stalled")
   // A result only follows a search cycle.
   `SR_ASSERT_SAME(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy), "stray result")
   // Results never come in consecutive cycles.
   `SR_ASSERT_NEXT(a_rsp_spacing, clock, reset, rsp_valid, !rsp_valid, "results too close")

endmodule

bind systematic_resampler_top sr_port_checker u_sr_port_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid)
);

// File: dv/tb_systematic_resampler_top.sv
module tb_systematic_resampler_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SEND_BUDGET    = 1050;
   localparam int CYCLE_LIMIT    = 2000000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int SETTLE_CYCLES  = 8;
   localparam int BIG_PASS_DRAWS = 24;
   localparam int SMALL_LIMIT    = 100;
   localparam int PLAN_ROWS      = 32;
   localparam logic [sr_pkg::SUM_W-1:0] SUM_CEIL = '1;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   sr_pkg::req_type               req_data;
   logic                          rsp_valid;
   sr_pkg::rsp_type               rsp_data;
   logic                          csr_we;
   logic [0:0]                    csr_index;
   logic [sr_pkg::CSR_DATA_W-1:0] csr_wdata;

   systematic_resampler_top u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Directed rows: a register write or a transaction, with an optional typed result.
   typedef struct {
      bit                            is_reg;
      sr_pkg::csr_index_type         reg_idx;
      logic [sr_pkg::CSR_DATA_W-1:0] reg_data;
      sr_pkg::op_type                op;
      logic [sr_pkg::WEIGHT_W-1:0]   weight;
      logic [sr_pkg::OFFS_W-1:0]     offs;
      bit                            typed;
      sr_pkg::rsp_type               want;
   } plan_row_type;

   plan_row_type plan [PLAN_ROWS];

   // Resampler mirror: configuration, cumulative table and pointers.
   logic [sr_pkg::CNT_W-1:0]  cfg_count = sr_pkg::COUNT_RESET;
   logic [sr_pkg::STEP_W-1:0] cfg_step  = sr_pkg::STEP_RESET;
   logic [sr_pkg::SUM_W-1:0]  cum_table [sr_pkg::MAX_PARTICLES];
   bit                        loaded_entry [sr_pkg::MAX_PARTICLES];
   logic [sr_pkg::SUM_W-1:0]  run_sum   = '0;
   logic [sr_pkg::SUM_W-1:0]  thr       = '0;
   int unsigned               load_pos  = 0;
   int unsigned               draw_pos  = 0;
   int unsigned               sel_pos   = 0;

   sr_pkg::rsp_type expected_draws [$];

   int unsigned sent_total      = 0;
   int unsigned loads_sent      = 0;
   int unsigned draws_sent      = 0;
   int unsigned reg_writes      = 0;
   int unsigned results_checked = 0;
   int unsigned clamped_seen    = 0;
   int unsigned passes_closed   = 0;
   int unsigned mismatch_count  = 0;
   int unsigned cycle_count     = 0;
   bit          steady          = 1'b0;

   function automatic int unsigned live_count();
      if (cfg_count == 0) return 1;
      if (cfg_count > sr_pkg::MAX_PARTICLES) return sr_pkg::MAX_PARTICLES;
      return cfg_count;
   endfunction

   function automatic logic [sr_pkg::SUM_W-1:0] add_clip(
         input logic [sr_pkg::SUM_W-1:0] a, input logic [sr_pkg::STEP_W-1:0] b);
      logic [sr_pkg::SUM_W:0] s;
      s = a + b;
      return (s > SUM_CEIL) ? SUM_CEIL : s[sr_pkg::SUM_W-1:0];
   endfunction

   // True once every particle in use has a cumulative entry since reset.
   function automatic bit set_loaded();
      for (int unsigned i = 0; i < live_count(); i++) begin
         if (!loaded_entry[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Advance the mirror by one transaction; return 1 with the selection for a draw.
   function automatic bit resample_predict(input sr_pkg::req_type r,
                                           output sr_pkg::rsp_type o);
      int unsigned n;
      int unsigned last_idx;
      n        = live_count();
      last_idx = n - 1;
      o        = '0;
      if (r.operation == sr_pkg::OP_LOAD) begin
         if (load_pos >= n) load_pos = 0;
         if (load_pos == 0) run_sum = '0;
         run_sum                = add_clip(run_sum, r.weight);
         cum_table[load_pos]    = run_sum;
         loaded_entry[load_pos] = 1'b1;
         load_pos++;
         if (load_pos >= n) load_pos = 0;
         return 1'b0;
      end
      if (draw_pos >= n) draw_pos = 0;
      if (draw_pos == 0) begin
         thr     = sr_pkg::SUM_W'(r.start_offset);
         sel_pos = 0;
      end else begin
         thr = add_clip(thr, cfg_step);
      end
      if (sel_pos > last_idx) sel_pos = last_idx;
      while (sel_pos < last_idx && thr > cum_table[sel_pos]) sel_pos++;
      o.particle_index = sr_pkg::IDX_W'(sel_pos);
      o.last_of_pass   = (draw_pos == last_idx);
      o.ran_past_end   = (thr > cum_table[sel_pos]);
      draw_pos++;
      if (draw_pos >= n) draw_pos = 0;
      return 1'b1;
   endfunction

   function automatic logic [sr_pkg::WEIGHT_W-1:0] random_weight(input int unsigned n);
      int unsigned pick;
      int unsigned top;
      pick = $urandom_range(0, 99);
      top  = 131072 / n;
      if (pick < 8) return '0;
      if (pick < 12) return '1;
      if (pick < 18) return sr_pkg::WEIGHT_W'($urandom);
      return sr_pkg::WEIGHT_W'($urandom_range(0, (top > 131071) ? 131071 : top));
   endfunction

   // Mostly an offset below the step, as software would pick it.
   function automatic logic [sr_pkg::OFFS_W-1:0] random_offset();
      int unsigned pick;
      int unsigned span;
      pick = $urandom_range(0, 99);
      span = (int'(cfg_step) > 65536) ? 65536 : int'(cfg_step);
      if (pick < 10) return '0;
      if (pick < 15) return '1;
      if (pick < 25 || span == 0) return sr_pkg::OFFS_W'($urandom);
      return sr_pkg::OFFS_W'($urandom_range(0, span - 1));
   endfunction

   function automatic sr_pkg::req_type make_item(input sr_pkg::op_type op,
                                                 input int unsigned n);
      sr_pkg::req_type r;
      r.operation    = op;
      r.weight       = random_weight(n);
      r.start_offset = random_offset();
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d want %0d (result %0d)",
                                   name, got, want, results_checked));
   endtask

   // Drive one transaction from a falling edge and hold it until accepted.
   task automatic send_item(input sr_pkg::req_type r, input bit typed,
                            input sr_pkg::rsp_type typed_rsp);
      sr_pkg::rsp_type o;
      bit              taken;
      if (!steady) begin
         while ($urandom_range(0, 99) < 38) begin
            start = 1'b0;
            @(negedge clock);
         end
      end
      start    = 1'b1;
      req_data = r;
      taken    = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
         if (taken) begin
            sent_total++;
            if (resample_predict(r, o)) begin
               expected_draws.push_back(typed ? typed_rsp : o);
               draws_sent++;
            end else begin
               loads_sent++;
            end
         end
         @(negedge clock);
      end
   endtask

   // Drain outstanding draws and let the block go idle before touching registers.
   task automatic settle();
      start = 1'b0;
      while (expected_draws.size() != 0) @(negedge clock);
      while (busy) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input sr_pkg::csr_index_type idx,
                            input logic [sr_pkg::CSR_DATA_W-1:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == sr_pkg::CSR_PARTICLE_COUNT) cfg_count = data[sr_pkg::CNT_W-1:0];
      else cfg_step = data[sr_pkg::STEP_W-1:0];
      reg_writes++;
   endtask

   // One setting, then load sets and draw passes, mostly well formed.
   task automatic run_phase(input bit big);
      int unsigned                   pick;
      int unsigned                   n;
      int unsigned                   segs;
      int unsigned                   len;
      logic [sr_pkg::CSR_DATA_W-1:0] count_word;
      logic [sr_pkg::CSR_DATA_W-1:0] step_word;
      sr_pkg::rsp_type               none;
      sr_pkg::op_type                op;
      none = '0;
      settle();
      pick = $urandom_range(0, 99);
      if (big) count_word = $urandom_range(0, 1) ? sr_pkg::CSR_DATA_W'(sr_pkg::MAX_PARTICLES)
                                                 : sr_pkg::CSR_DATA_W'(11'h7FF);
      else if (pick < 60) count_word = sr_pkg::CSR_DATA_W'($urandom_range(1, 8));
      else if (pick < 85) count_word = sr_pkg::CSR_DATA_W'($urandom_range(9, 32));
      else if (pick < 95) count_word = sr_pkg::CSR_DATA_W'($urandom_range(33, 100));
      else count_word = '0;
      if ($urandom_range(0, 99) < 20)
         count_word[sr_pkg::CSR_DATA_W-1:sr_pkg::CNT_W] =
            (sr_pkg::CSR_DATA_W-sr_pkg::CNT_W)'($urandom);
      // Always write the count in a big phase or when the live count is above SMALL_LIMIT.
      if (big || live_count() > SMALL_LIMIT || $urandom_range(0, 99) < 85)
         write_reg(sr_pkg::CSR_PARTICLE_COUNT, count_word);
      n    = live_count();
      pick = $urandom_range(0, 99);
      if (big) step_word = sr_pkg::CSR_DATA_W'($urandom_range(1, 128));
      else if (pick < 60) step_word = sr_pkg::CSR_DATA_W'(65536 / n);
      else if (pick < 75) step_word = sr_pkg::CSR_DATA_W'($urandom_range(1, 131071));
      else if (pick < 85) step_word = sr_pkg::CSR_DATA_W'(1);
      else if (pick < 92) step_word = sr_pkg::CSR_DATA_W'(65536);
      else step_word = sr_pkg::CSR_DATA_W'(131071);
      if (big || $urandom_range(0, 99) < 85) write_reg(sr_pkg::CSR_THRESHOLD_STEP, step_word);
      segs = big ? 1 : $urandom_range(1, 3);
      repeat (segs) begin
         if (big || $urandom_range(0, 99) < 80) begin
            // Full load set, then whole passes (a partial one at the largest count);
            // the first half of the largest set goes back to back.
            for (int unsigned i = 0; i < n; i++) begin
               steady = big && (i < n / 2);
               send_item(make_item(sr_pkg::OP_LOAD, n), 1'b0, none);
            end
            steady = 1'b0;
            len = big ? BIG_PASS_DRAWS : $urandom_range(1, 2) * n;
            repeat (len) send_item(make_item(sr_pkg::OP_DRAW, n), 1'b0, none);
         end else begin
            // Mixed loads and draws that break sets and passes at random points.
            len = $urandom_range(1, 2 * n + 2);
            repeat (len) begin
               op = ($urandom_range(0, 1) && set_loaded()) ? sr_pkg::OP_DRAW
                                                           : sr_pkg::OP_LOAD;
               send_item(make_item(op, n), 1'b0, none);
            end
         end
      end
   endtask

   // Compare each strobed result with the oldest outstanding draw.
   always @(posedge clock) begin : result_check
      sr_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_draws.size() == 0) begin
            report_mismatch("result strobe with no draw outstanding");
         end else begin
            want = expected_draws.pop_front();
            check_field("particle_index", rsp_data.particle_index, want.particle_index);
            check_field("last_of_pass", rsp_data.last_of_pass, want.last_of_pass);
            check_field("ran_past_end", rsp_data.ran_past_end, want.ran_past_end);
            results_checked++;
            if (want.ran_past_end) clamped_seen++;
            if (want.last_of_pass) passes_closed++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d draws outstanding",
                  cycle_count, expected_draws.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      sr_pkg::req_type r;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      plan = '{
         // Four particles with zero, unit, full-scale and zero weights.
         '{1'b1, sr_pkg::CSR_PARTICLE_COUNT, 17'd4, sr_pkg::OP_LOAD, 17'd0, 16'd0,
           1'b0, '{10'd0, 1'b0, 1'b0}},
         '{1'b1, sr_pkg::CSR_THRESHOLD_STEP, 17'd16384, sr_pkg::OP_LOAD, 17'd0, 16'd0,
           1'b0, '0},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_LOAD, 17'd0, 16'd0,
           1'b0, '0},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_LOAD, 17'd65536, 16'd0,
           1'b0, '0},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_LOAD, 17'd131071, 16'd0,
           1'b0, '0},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_LOAD, 17'd0, 16'd0,
           1'b0, '0},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_DRAW, 17'd0, 16'd0,
           1'b1, '{10'd0, 1'b0, 1'b0}},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_DRAW, 17'd0, 16'd0,
           1'b0, '0},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_DRAW, 17'd0, 16'd0,
           1'b0, '0},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_DRAW, 17'd0, 16'd0,
           1'b0, '0},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_DRAW, 17'd0, 16'd65535,
           1'b0, '0},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_DRAW, 17'd0, 16'd0,
           1'b0, '0},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_DRAW, 17'd0, 16'd0,
           1'b0, '0},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_DRAW, 17'd0, 16'd0,
           1'b0, '0},
         // Two tiny weights: every threshold runs past the end.
         '{1'b1, sr_pkg::CSR_PARTICLE_COUNT, 17'd2, sr_pkg::OP_LOAD, 17'd0, 16'd0,
           1'b0, '0},
         '{1'b1, sr_pkg::CSR_THRESHOLD_STEP, 17'd65536, sr_pkg::OP_LOAD, 17'd0, 16'd0,
           1'b0, '0},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_LOAD, 17'd1, 16'd0,
           1'b0, '0},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_LOAD, 17'd1, 16'd0,
           1'b0, '0},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_DRAW, 17'd0, 16'd65535,
           1'b1, '{10'd1, 1'b0, 1'b1}},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_DRAW, 17'd0, 16'd0,
           1'b1, '{10'd1, 1'b1, 1'b1}},
         // Count zero acts as a single particle: every draw closes its pass.
         '{1'b1, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_LOAD, 17'd0, 16'd0,
           1'b0, '0},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_DRAW, 17'd0, 16'd0,
           1'b1, '{10'd0, 1'b1, 1'b0}},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_DRAW, 17'd0, 16'd5,
           1'b1, '{10'd0, 1'b1, 1'b1}},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_LOAD, 17'd131071, 16'd0,
           1'b0, '0},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_DRAW, 17'd0, 16'd65535,
           1'b1, '{10'd0, 1'b1, 1'b0}},
         // Smallest and largest step, count written with junk above its field.
         '{1'b1, sr_pkg::CSR_THRESHOLD_STEP, 17'd1, sr_pkg::OP_LOAD, 17'd0, 16'd0,
           1'b0, '0},
         '{1'b1, sr_pkg::CSR_PARTICLE_COUNT, 17'h1F803, sr_pkg::OP_LOAD, 17'd0, 16'd0,
           1'b0, '0},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_DRAW, 17'd0, 16'd65535,
           1'b0, '0},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_DRAW, 17'd0, 16'd0,
           1'b0, '0},
         '{1'b1, sr_pkg::CSR_THRESHOLD_STEP, 17'd131071, sr_pkg::OP_LOAD, 17'd0, 16'd0,
           1'b0, '0},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_DRAW, 17'd0, 16'hAAAA,
           1'b0, '0},
         '{1'b0, sr_pkg::CSR_PARTICLE_COUNT, 17'd0, sr_pkg::OP_DRAW, 17'd0, 16'h5555,
           1'b0, '0}
      };

      // Hold reset, then release it on a falling edge.
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the directed table.
      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            settle();
            write_reg(plan[i].reg_idx, plan[i].reg_data);
         end else begin
            r.operation    = plan[i].op;
            r.weight       = plan[i].weight;
            r.start_offset = plan[i].offs;
            send_item(r, plan[i].typed, plan[i].want);
         end
      end

      // One set at the full count, then small counts that start on the stale
      // positions it leaves, until the transaction budget is spent.
      run_phase(1'b1);
      do begin
         run_phase(1'b0);
      end while (sent_total < SEND_BUDGET);

      // Drain and let any late strobe show up.
      start = 1'b0;
      while (expected_draws.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_draws.size() != 0)
         report_mismatch($sformatf("%0d draws never produced a result", expected_draws.size()));

      $display("Sent %0d loads and %0d draws across %0d register writes; %0d results checked.",
               loads_sent, draws_sent, reg_writes, results_checked);
      $display("Saw %0d completed passes and %0d clamped draws; %0d mismatches.",
               passes_closed, clamped_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
